[rtl/sstf_request_scheduler_assert.svh]
// Assertion macros used by the scheduler checker.
`ifndef SSTF_REQUEST_SCHEDULER_ASSERT_SVH
`define SSTF_REQUEST_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SSTF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is low.
`define SSTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[rtl/sstf_pkg.sv]
// Types and constants of the SSTF request scheduler.
package sstf_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TAG_BITS    = 8;

    localparam int OPC_W       = 2;
    localparam int TAG_FIELD_W = 8;
    localparam int POS_W       = 48;

    localparam int KTAG_W  = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = KTAG_W + POS_W;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REMOVE   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_COMPACT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OPC_W-1:0]       opcode;
        logic [TAG_FIELD_W-1:0] request_tag;
        logic [POS_W-1:0]       request_position;
    } in_beat_t;

    typedef struct packed {
        logic                   dispatch_valid;
        logic [TAG_FIELD_W-1:0] dispatched_tag;
        logic [POS_W-1:0]       dispatched_position;
        logic [1:0]             status;
        logic                   queue_empty;
    } out_beat_t;

endpackage

[rtl/sstf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sstf_request_scheduler.sv]
// Shortest-seek-time-first request scheduler top level.
//
// Pending requests sit in one RAM in arrival order; a single read port feeds a
// distance unit (two subtracts and one compare) and later the compaction
// that closes the gap left by a dispatched or removed entry. The block takes one
// beat at a time. Add, the unused opcode and any beat on an empty table go from
// the execute state straight to the result. Dispatch and remove on a non-empty
// table scan every pending entry and then compact the entries behind the slot
// that is taken out; a remove that finds nothing skips the compaction. Stalls on
// m_ready hold the block: the result is held in an output register until taken,
// and the next beat can be accepted in the cycle after the result is loaded.
module sstf_request_scheduler
    import sstf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    state_t state_reg, state_next;

    logic [OPC_W-1:0]  op_reg;
    logic [KTAG_W-1:0] tag_reg;
    logic [POS_W-1:0]  pos_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0] rd_reg, rd_next;

    logic             p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0] p1_idx_reg, p1_idx_next;

    logic              p2_valid_reg, p2_valid_next;
    logic [IDX_W-1:0]  p2_idx_reg;
    logic [KTAG_W-1:0] p2_tag_reg;
    logic [POS_W-1:0]  p2_pos_reg;
    logic [POS_W-1:0]  p2_dist_reg;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [POS_W-1:0]  best_dist_reg, best_dist_next;
    logic [KTAG_W-1:0] best_tag_reg, best_tag_next;
    logic [POS_W-1:0]  best_pos_reg, best_pos_next;

    status_t status_reg, status_next;

    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg, m_data_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [KTAG_W-1:0] rd_tag;
    logic [POS_W-1:0]  rd_pos;
    logic [POS_W:0]    diff_up;
    logic [POS_W-1:0]  diff_down;
    logic [POS_W-1:0]  cand_dist;

    logic      issue;
    logic      sweep_idle;
    logic      out_free;
    logic      dispatched;
    out_beat_t result;

    sstf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_tag    = ram_rdata[ENTRY_W-1:POS_W];
    assign rd_pos    = ram_rdata[POS_W-1:0];
    assign diff_up   = {1'b0, rd_pos} - {1'b0, last_reg};
    assign diff_down = last_reg - rd_pos;
    assign cand_dist = diff_up[POS_W] ? diff_down : diff_up[POS_W-1:0];

    assign issue      = ((state_reg == S_SCAN) || (state_reg == S_COMPACT))
                        && (rd_reg < count_reg);
    assign sweep_idle = !issue && !p1_valid_reg && !p2_valid_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign ram_raddr  = rd_reg[IDX_W-1:0];

    assign dispatched = (op_reg == OP_DISPATCH) && (status_reg == ST_OK);

    always_comb begin
        result                     = '0;
        result.dispatch_valid      = dispatched;
        result.dispatched_tag      = dispatched ? TAG_FIELD_W'(best_tag_reg) : '0;
        result.dispatched_position = dispatched ? best_pos_reg : '0;
        result.status              = status_reg;
        result.queue_empty         = (count_reg == '0);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (op_reg)
                    OP_DISPATCH,
                    OP_REMOVE: state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (sweep_idle) begin
                    state_next = (op_reg == OP_DISPATCH || found_reg) ? S_COMPACT : S_DONE;
                end
            end
            S_COMPACT: begin
                if (sweep_idle) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        last_next      = last_reg;
        rd_next        = rd_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = p1_idx_reg;
        p2_valid_next  = 1'b0;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_tag_next  = best_tag_reg;
        best_pos_next  = best_pos_reg;
        status_next    = status_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = {tag_reg, pos_reg};

        unique case (state_reg)
            S_IDLE: begin
            end
            S_EXEC: begin
                rd_next     = '0;
                found_next  = 1'b0;
                status_next = ST_OK;
                unique case (op_reg)
                    OP_ADD: begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_DISPATCH: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end
                    end
                    OP_REMOVE: begin
                        if (count_reg == '0) begin
                            status_next = ST_NOTFOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (issue) begin
                    p1_valid_next = 1'b1;
                    p1_idx_next   = rd_reg[IDX_W-1:0];
                    rd_next       = rd_reg + CNT_W'(1);
                end
                p2_valid_next = p1_valid_reg;
                if (p2_valid_reg) begin
                    if (op_reg == OP_DISPATCH) begin
                        if (!found_reg || (p2_dist_reg < best_dist_reg)) begin
                            found_next     = 1'b1;
                            best_idx_next  = p2_idx_reg;
                            best_dist_next = p2_dist_reg;
                            best_tag_next  = p2_tag_reg;
                            best_pos_next  = p2_pos_reg;
                        end
                    end else if (!found_reg && (p2_tag_reg == tag_reg)) begin
                        found_next    = 1'b1;
                        best_idx_next = p2_idx_reg;
                    end
                end
                if (sweep_idle) begin
                    rd_next = CNT_W'(best_idx_reg) + CNT_W'(1);
                    if (op_reg != OP_DISPATCH && !found_reg) begin
                        status_next = ST_NOTFOUND;
                    end
                end
            end
            S_COMPACT: begin
                if (issue) begin
                    p1_valid_next = 1'b1;
                    p1_idx_next   = IDX_W'(rd_reg - CNT_W'(1));
                    rd_next       = rd_reg + CNT_W'(1);
                end
                if (p1_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = p1_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (sweep_idle) begin
                    count_next = count_reg - CNT_W'(1);
                    if (op_reg == OP_DISPATCH) begin
                        last_next = best_pos_reg;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            last_reg     <= '0;
            rd_reg       <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            status_reg   <= ST_OK;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            rd_reg       <= rd_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_data.opcode;
            tag_reg <= s_data.request_tag[KTAG_W-1:0];
            pos_reg <= s_data.request_position;
        end
        p1_idx_reg    <= p1_idx_next;
        p2_idx_reg    <= p1_idx_reg;
        p2_tag_reg    <= rd_tag;
        p2_pos_reg    <= rd_pos;
        p2_dist_reg   <= cand_dist;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_tag_reg  <= best_tag_next;
        best_pos_reg  <= best_pos_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/sstf_checker.sv]
// Port-level checker for the SSTF request scheduler, with its bind.
`include "sstf_request_scheduler_assert.svh"

module sstf_checker
    import sstf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    `SSTF_ASSERT_NEXT(a_result_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data))
    `SSTF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SSTF_ASSERT_IMPLY(a_idle_fields_zero, aclk, aresetn,
        m_valid && !m_data.dispatch_valid,
        (m_data.dispatched_tag == '0) && (m_data.dispatched_position == '0))
    `SSTF_ASSERT_IMPLY(a_dispatch_ok, aclk, aresetn,
        m_valid && m_data.dispatch_valid, m_data.status == ST_OK)
    `SSTF_ASSERT_IMPLY(a_empty_flag, aclk, aresetn,
        m_valid && (m_data.status == ST_EMPTY),
        m_data.queue_empty && !m_data.dispatch_valid)

endmodule

bind sstf_request_scheduler sstf_checker u_sstf_checker (.*);

[sim/sstf_request_scheduler_tb.sv]
// Self-checking testbench for the SSTF request scheduler: directed and random beats.
module sstf_request_scheduler_tb
    import sstf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPC_W-1:0] OPC_UNUSED   = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
    localparam int               RANDOM_ITEMS = 1800;
    localparam int               DRAIN_CYCLES = 200;
    localparam int               TIMEOUT_NS   = 2_000_000;
    localparam int               REPORT_LIMIT = 10;

    typedef enum {TR_FILL, TR_DRAIN, TR_BALANCED} traffic_t;

    class sstf_scoreboard;
        logic [KTAG_W-1:0] pend_tag[$];
        logic [POS_W-1:0]  pend_pos[$];
        logic [POS_W-1:0]  last_pos;
        out_beat_t         expected_q[$];
        int                mismatches;

        function new();
            last_pos   = '0;
            mismatches = 0;
        endfunction

        function void note_beat(in_beat_t b);
            out_beat_t         r;
            logic [POS_W-1:0]  cur_dist;
            logic [POS_W-1:0]  best_dist;
            logic [KTAG_W-1:0] tag;
            int                best;
            bit                found;
            r      = '0;
            r.status = ST_OK;
            tag    = b.request_tag[KTAG_W-1:0];
            case (b.opcode)
                OP_ADD: begin
                    if (pend_pos.size() >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pend_tag.push_back(tag);
                        pend_pos.push_back(b.request_position);
                    end
                end
                OP_DISPATCH: begin
                    if (pend_pos.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        best = 0;
                        best_dist = seek_dist(last_pos, pend_pos[0]);
                        for (int k = 1; k < pend_pos.size(); k++) begin
                            cur_dist = seek_dist(last_pos, pend_pos[k]);
                            if (cur_dist < best_dist) begin
                                best_dist = cur_dist;
                                best = k;
                            end
                        end
                        r.dispatch_valid      = 1'b1;
                        r.dispatched_tag      = TAG_FIELD_W'(pend_tag[best]);
                        r.dispatched_position = pend_pos[best];
                        last_pos = pend_pos[best];
                        pend_tag.delete(best);
                        pend_pos.delete(best);
                    end
                end
                OP_REMOVE: begin
                    found = 1'b0;
                    for (int k = 0; k < pend_tag.size() && !found; k++) begin
                        if (pend_tag[k] == tag) begin
                            pend_tag.delete(k);
                            pend_pos.delete(k);
                            found = 1'b1;
                        end
                    end
                    if (!found) r.status = ST_NOTFOUND;
                end
                default: ;
            endcase
            r.queue_empty = (pend_pos.size() == 0);
            expected_q.push_back(r);
        endfunction

        function logic [POS_W-1:0] seek_dist(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void report(string what, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
        endfunction

        function void check_result(out_beat_t r);
            out_beat_t e;
            if (expected_q.size() == 0) begin
                report("unexpected result beat", '0, POS_W'(r));
                return;
            end
            e = expected_q.pop_front();
            if (r.dispatch_valid !== e.dispatch_valid)
                report("dispatch_valid", POS_W'(e.dispatch_valid), POS_W'(r.dispatch_valid));
            if (r.dispatched_tag !== e.dispatched_tag)
                report("dispatched_tag", POS_W'(e.dispatched_tag), POS_W'(r.dispatched_tag));
            if (r.dispatched_position !== e.dispatched_position)
                report("dispatched_position", e.dispatched_position, r.dispatched_position);
            if (r.status !== e.status)
                report("status", POS_W'(e.status), POS_W'(r.status));
            if (r.queue_empty !== e.queue_empty)
                report("queue_empty", POS_W'(e.queue_empty), POS_W'(r.queue_empty));
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;
    bit        idle_en = 1'b1;

    sstf_scoreboard sb = new();

    sstf_request_scheduler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= !(idle_en && $urandom_range(99) < 12);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_beat(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    function automatic in_beat_t beat_of(logic [OPC_W-1:0] op, logic [TAG_FIELD_W-1:0] tag,
                                         logic [POS_W-1:0] pos);
        in_beat_t b;
        b.opcode           = op;
        b.request_tag      = tag;
        b.request_position = pos;
        return b;
    endfunction

    function automatic logic [OPC_W-1:0] pick_opcode(traffic_t t);
        int r;
        r = $urandom_range(99);
        case (t)
            TR_FILL:  return r < 75 ? OP_ADD : r < 88 ? OP_DISPATCH :
                             r < 98 ? OP_REMOVE : OPC_UNUSED;
            TR_DRAIN: return r < 20 ? OP_ADD : r < 80 ? OP_DISPATCH :
                             r < 98 ? OP_REMOVE : OPC_UNUSED;
            default:  return r < 45 ? OP_ADD : r < 80 ? OP_DISPATCH :
                             r < 97 ? OP_REMOVE : OPC_UNUSED;
        endcase
    endfunction

    function automatic in_beat_t random_beat(logic [OPC_W-1:0] op);
        logic [63:0]            w;
        logic [TAG_FIELD_W-1:0] tag;
        logic [POS_W-1:0]       pos;
        int                     r;
        int                     n;
        w   = {$urandom(), $urandom()};
        pos = w[POS_W-1:0];
        tag = ($urandom_range(1) == 0) ? TAG_FIELD_W'($urandom_range(7)) :
                                         TAG_FIELD_W'($urandom_range(255));
        n   = sb.pend_pos.size();
        if (op == OP_REMOVE && n > 0 && $urandom_range(99) < 70)
            tag = TAG_FIELD_W'(sb.pend_tag[$urandom_range(n - 1)]);
        if (op == OP_ADD) begin
            r = $urandom_range(99);
            if (r < 35) begin
                pos = ($urandom_range(1) == 0) ? sb.last_pos + $urandom_range(1000) :
                                                 sb.last_pos - $urandom_range(1000);
            end else if (r < 45 && n > 0) begin
                pos = (sb.last_pos << 1) - sb.pend_pos[$urandom_range(n - 1)];
            end else if (r < 55 && n > 0) begin
                pos = sb.pend_pos[$urandom_range(n - 1)];
            end else if (r < 60) begin
                pos = ($urandom_range(1) == 0) ? '0 : POS_MAX;
            end
        end
        return beat_of(op, tag, pos);
    endfunction

    task automatic send_beat(input in_beat_t b);
        while (idle_en && $urandom_range(99) < 12) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        traffic_t         traffic;
        logic [OPC_W-1:0] op;
        int               block_left;
        int               sent;
        traffic    = TR_BALANCED;
        block_left = 0;
        sent       = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_REMOVE,   8'd3,   '0));
        send_beat(beat_of(OPC_UNUSED,  8'd255, POS_MAX));
        send_beat(beat_of(OP_ADD,      8'd0,   POS_MAX));
        send_beat(beat_of(OP_ADD,      8'd255, '0));
        send_beat(beat_of(OP_ADD,      8'd255, 48'd20));
        send_beat(beat_of(OP_ADD,      8'd17,  48'd20));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_REMOVE,   8'd17,  '0));
        send_beat(beat_of(OP_ADD,      8'd40,  48'd30));
        send_beat(beat_of(OP_ADD,      8'd41,  48'd10));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_REMOVE,   8'd0,   '0));
        send_beat(beat_of(OP_ADD,      8'd9,   48'd5));
        send_beat(beat_of(OP_ADD,      8'd9,   48'd6));
        send_beat(beat_of(OP_REMOVE,   8'd9,   '0));
        send_beat(beat_of(OPC_UNUSED,  8'd0,   '0));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_ADD,      8'd128, POS_MAX));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));
        send_beat(beat_of(OP_ADD,      8'd1,   '0));
        send_beat(beat_of(OP_DISPATCH, 8'd0,   '0));

        while (sent < RANDOM_ITEMS) begin
            if (block_left == 0) begin
                traffic    = traffic_t'($urandom_range(2));
                block_left = $urandom_range(40, 120);
            end
            block_left--;
            idle_en = !(sent >= 700 && sent < 1100);
            op = pick_opcode(traffic);
            send_beat(random_beat(op));
            if (op != OPC_UNUSED) sent++;
        end
        s_valid = 1'b0;
        idle_en = 1'b1;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/sstf_pkg.sv
rtl/sstf_ram.sv
rtl/sstf_request_scheduler.sv
rtl/sstf_checker.sv
sim/sstf_request_scheduler_tb.sv
